[src/dkt_pkg.sv]
package dkt_pkg;

  // Default table depth.
  localparam int DKT_ENTRIES = 16;

  // Widths of the fixed payload fields.
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int KEY_W   = 16;
  localparam int ROUTE_W = 24;
  localparam int INDEX_W = 4;
  localparam int USED_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_EMPTY  = 2'd3
  } dkt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted item and restart the scan
    logic scan_en;  // walk the key store, one entry per cycle
    logic commit;   // apply the operation and load the result registers
  } dkt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // the last entry is being checked this cycle
  } dkt_status_t;

endpackage

[src/dkt_ram.sv]
module dkt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/dkt_ctrl.sv]
module dkt_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [dkt_pkg::OP_W-1:0] in_operation,
  output logic                    out_valid,
  input  logic                    out_ready,
  output dkt_pkg::dkt_cmd_t       cmd,
  input  dkt_pkg::dkt_status_t    status
);
  import dkt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (dkt_op_t'(in_operation) == OP_EMPTY) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The result register must be free before it is overwritten.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/dkt_datapath.sv]
module dkt_datapath #(
  parameter int ENTRIES = dkt_pkg::DKT_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dkt_pkg::dkt_cmd_t            cmd,
  output dkt_pkg::dkt_status_t         status,
  input  logic [dkt_pkg::OP_W-1:0]     in_operation,
  input  logic [dkt_pkg::BYTE_W-1:0]   in_device_low,
  input  logic [dkt_pkg::BYTE_W-1:0]   in_device_high,
  input  logic [dkt_pkg::BYTE_W-1:0]   in_route_first,
  input  logic [dkt_pkg::BYTE_W-1:0]   in_route_second,
  input  logic [dkt_pkg::BYTE_W-1:0]   in_route_third,
  output logic                         out_found,
  output logic [dkt_pkg::INDEX_W-1:0]  out_entry_index,
  output logic                         out_success,
  output logic [dkt_pkg::USED_W-1:0]   out_entries_used
);
  import dkt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Captured item.
  dkt_op_t              op_r;
  logic [KEY_W-1:0]     key_r;
  logic [ROUTE_W-1:0]   route_r;

  // Scan control.
  logic [IDX_W-1:0]     addr_r;
  logic                 pend_r;
  logic                 chk_r;
  logic [IDX_W-1:0]     chk_idx_r;

  // Scan results.
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;

  // Table state.
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [KEY_W-1:0]     key_rd;
  logic                 rd_en;
  logic                 ins_en;
  logic                 match;
  logic                 vacant;
  logic [IDX_W+INDEX_W-1:0] idx_ext;
  logic [CNT_W+USED_W-1:0]  cnt_ext;

  assign rd_en  = cmd.scan_en && pend_r;
  assign match  = valid_r[chk_idx_r] && (key_rd == key_r);
  assign vacant = !valid_r[chk_idx_r];
  assign ins_en = cmd.commit && (op_r == OP_ADD) && !hit_r && free_r;

  assign status.scan_done = chk_r && (chk_idx_r == LAST_IDX);

  dkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (ins_en),
    .waddr (free_idx_r),
    .wdata (key_r),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (key_rd)
  );

  // Routes are kept for the host but never read back here.
  dkt_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_route_ram (
    .clk   (clk),
    .we    (ins_en),
    .waddr (free_idx_r),
    .wdata (route_r),
    .re    (1'b0),
    .raddr (addr_r),
    .rdata ()
  );

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (cmd.commit) begin
      case (op_r)
        OP_ADD: begin
          if (ins_en) begin
            valid_nxt[free_idx_r] = 1'b1;
            cnt_nxt               = cnt_r + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (hit_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
        end
        OP_EMPTY: begin
          valid_nxt = '0;
          cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign idx_ext = {{INDEX_W{1'b0}}, hit_idx_r};
  assign cnt_ext = {{USED_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      chk_r   <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= rd_en;
      if (cmd.load) begin
        pend_r <= 1'b1;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (rd_en && (addr_r == LAST_IDX)) begin
          pend_r <= 1'b0;
        end
        if (chk_r && match) begin
          hit_r <= 1'b1;
        end
        if (chk_r && vacant) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= dkt_op_t'(in_operation);
      key_r   <= {in_device_high, in_device_low};
      route_r <= {in_route_first, in_route_second, in_route_third};
      addr_r  <= '0;
    end else if (rd_en && (addr_r != LAST_IDX)) begin
      addr_r <= addr_r + IDX_W'(1);
    end
    if (rd_en) begin
      chk_idx_r <= addr_r;
    end
    // Only the lowest matching and the lowest vacant entry are kept.
    if (chk_r && match && !hit_r) begin
      hit_idx_r <= chk_idx_r;
    end
    if (chk_r && vacant && !free_r) begin
      free_idx_r <= chk_idx_r;
    end
    if (cmd.commit) begin
      out_found        <= (op_r == OP_FIND) && hit_r;
      out_entry_index  <= ((op_r == OP_FIND) && hit_r) ? idx_ext[INDEX_W-1:0] : '0;
      out_success      <= (op_r == OP_ADD) ? ins_en : (op_r != OP_FIND);
      out_entries_used <= cnt_ext[USED_W-1:0];
    end
  end

endmodule

[src/device_key_table.sv]
// A find, add or delete item walks the key store, then commits and registers its result.
// An empty-table item skips the walk and goes straight to the commit step.
// A new item is taken only after the last one commits; the key store has a single read port.
// The result register frees the input side while a result still waits to be taken.
// Reset (rst_n low, synchronous) clears every valid mark, the used count and the handshakes.
module device_key_table #(
  parameter int ENTRIES = dkt_pkg::DKT_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dkt_pkg::OP_W-1:0]    in_operation,
  input  logic [dkt_pkg::BYTE_W-1:0]  in_device_low,
  input  logic [dkt_pkg::BYTE_W-1:0]  in_device_high,
  input  logic [dkt_pkg::BYTE_W-1:0]  in_route_first,
  input  logic [dkt_pkg::BYTE_W-1:0]  in_route_second,
  input  logic [dkt_pkg::BYTE_W-1:0]  in_route_third,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [dkt_pkg::INDEX_W-1:0] out_entry_index,
  output logic                        out_success,
  output logic [dkt_pkg::USED_W-1:0]  out_entries_used
);
  import dkt_pkg::*;

  // The controller sequences each item through three steps. It captures the
  // item, then walks the key store one entry per cycle while the datapath
  // notes the lowest valid entry with the same key and the lowest free entry.
  // Finally it commits the operation and loads the result register. An
  // empty-table item skips the walk, since it needs no lookup.
  dkt_cmd_t    cmd;
  dkt_status_t status;

  dkt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // The datapath holds the valid marks in flip-flops so that reset and the
  // empty-table item clear them at once, while keys and routes live in RAM.
  dkt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (in_operation),
    .in_device_low    (in_device_low),
    .in_device_high   (in_device_high),
    .in_route_first   (in_route_first),
    .in_route_second  (in_route_second),
    .in_route_third   (in_route_third),
    .out_found        (out_found),
    .out_entry_index  (out_entry_index),
    .out_success      (out_success),
    .out_entries_used (out_entries_used)
  );

  // The store is never walked while a new item can be taken.
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !cmd.scan_en)
    else $error("key store scan active while the input side is open");

  // Every commit presents a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.commit |=> out_valid)
    else $error("commit did not produce a result item");

  // A find result never reports success, and a hit is only reported by a find.
  assert property (@(posedge clk) disable iff (!rst_n) (out_valid && out_found) |-> !out_success)
    else $error("find result with success set");

  // A commit never happens while an untaken result still occupies the register.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cmd.commit && out_valid) |-> out_ready)
    else $error("result register overwritten before it was taken");

endmodule
